### sv/assert_macros.svh
// Assertion macros used by the interpolator core.
// Needs nothing else; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### sv/pgki_pkg.sv
// Types and constants of the polar grid kernel interpolator.
// Used by every module of the block; depends on nothing.
package pgki_pkg;

    localparam logic [1:0] ACT_GRID_WR = 2'd0;
    localparam logic [1:0] ACT_KERN_WR = 2'd1;
    localparam logic [1:0] ACT_QUERY   = 2'd2;

    localparam logic [1:0] CFG_ANGLE_COUNT  = 2'd0;
    localparam logic [1:0] CFG_BORDER_WIDTH = 2'd1;
    localparam logic [1:0] CFG_TAP_COUNT    = 2'd2;
    localparam logic [1:0] CFG_OVERSAMPLE   = 2'd3;

    localparam logic [10:0] RST_ANGLE_COUNT  = 11'd512;
    localparam logic [2:0]  RST_BORDER_WIDTH = 3'd1;
    localparam logic [3:0]  RST_TAP_COUNT    = 4'd4;
    localparam logic [9:0]  RST_OVERSAMPLE   = 10'd512;

    // Signed width of a linear grid address, enough for every field pattern.
    localparam int ADDR_W = 28;
    // Width of a kernel table index before the range check.
    localparam int KIDX_W = 17;
    // Dividend of the bilinear rounding offset quotient (half a Q16 step).
    localparam logic [15:0] RECIP_NUM = 16'h8000;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_DIV, S_POS, S_BASE, S_KLOAD, S_RUN, S_DRAIN, S_FIN
    } t_state;

    typedef struct packed {
        logic               clr;
        logic               vld;
        logic               last_k;
        logic               last_j;
        logic               bil;
        logic signed [31:0] word;
        logic signed [17:0] kx;
        logic signed [17:0] ky;
    } t_mac_ctl;

    typedef struct packed {
        logic               done;
        logic signed [31:0] sample;
    } t_mac_res;

endpackage

### sv/polar_grid_kernel_interpolator_core.sv
// Top level: configuration, grid and kernel memories, query sequencer.
// Depends on pgki_pkg, pgki_recip, pgki_mac and assert_macros.svh.
//
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------------------------
//  input   | i_in_valid / o_in_stall    | i_action i_address i_write_value i_radius i_angle
//  output  | o_out_valid / i_out_stall  | o_sample o_out_of_range
//  config  | i_cfg_we                   | i_cfg_index i_cfg_data
//
// A grid or kernel write is stored as it is accepted. A table query with T taps
// makes T*T single-port grid reads after 2*T kernel reads. A bilinear query reads
// no kernel rows and waits for the 16-step serial divider that gives the rounding
// offset. Reset needs no clearing pass: both memories are undefined until written.
// A result waits in the output register while the next item is taken; a query
// finishing into a stalled output waits.
`include "assert_macros.svh"
module polar_grid_kernel_interpolator_core #(
    parameter int GRID_DEPTH   = 131072,
    parameter int KERNEL_DEPTH = 4096,
    parameter int MAX_TAPS     = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic [16:0]        i_address,
    input  logic signed [31:0] i_write_value,
    input  logic [23:0]        i_radius,
    input  logic [15:0]        i_angle,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_sample,
    output logic               o_out_of_range,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [10:0]        i_cfg_data
);

    localparam int GAW = $clog2(GRID_DEPTH);
    localparam int KAW = $clog2(KERNEL_DEPTH);
    localparam int TW  = $clog2(MAX_TAPS + 1);
    localparam int KW  = $clog2(MAX_TAPS);
    localparam int AW  = pgki_pkg::ADDR_W;
    localparam int IW  = pgki_pkg::KIDX_W;

    pgki_pkg::t_state r_state, n_state;

    logic [10:0] r_ac;
    logic [2:0]  r_bw;
    logic [3:0]  r_tap;
    logic [9:0]  r_os_cfg;

    logic [23:0] r_rad;
    logic [14:0] r_ang;
    logic [9:0]  r_os;
    logic        r_bil;
    logic [26:0] r_p;
    logic [21:0] r_ryp;
    logic [12:0] r_row;
    logic [11:0] r_width;
    logic [TW-1:0] r_tc;
    logic [TW-1:0] r_half;
    logic [26:0] r_rr;
    logic [11:0] r_col;
    logic [9:0]  r_rx;
    logic [9:0]  r_ry;
    logic [16:0] r_wx;
    logic [AW-1:0] r_rowaddr;
    logic [14:0] r_kxb;
    logic [14:0] r_kyb;
    logic [TW:0]   r_kc;
    logic [KW-1:0] r_k, r_j;
    logic        r_flag;

    logic signed [17:0] r_kx [MAX_TAPS];
    logic signed [17:0] r_ky [MAX_TAPS];

    logic [31:0] grid_mem [GRID_DEPTH];
    logic [17:0] kern_mem [KERNEL_DEPTH];
    logic [31:0] r_grid_q;
    logic [17:0] r_kern_q;

    logic          r_kl_vld, r_kl_oob, r_kl_isy;
    logic [KW-1:0] r_kl_pos;
    logic          r_p1_vld, r_p1_oor, r_p1_lastk, r_p1_lastj;
    logic [KW-1:0] r_p1_k, r_p1_j;

    logic        in_acc, query_acc, out_free;
    logic        grid_re, kern_re, out_load;
    logic [9:0]  os_eff;
    logic [TW-1:0] tc_tab;
    logic [25:0] den;
    logic        carry;
    logic [26:0] rem;
    logic [17:0] wx_n;
    logic signed [14:0] row_s;
    logic signed [13:0] col_s;
    logic [AW-1:0] issue_addr;
    logic        oor;
    logic        lastk, lastj, kl_last;
    logic        kl_isy;
    logic [KW-1:0] kl_pos;
    logic [IW-1:0] kidx;
    logic [15:0] quot;
    logic        div_busy;

    pgki_pkg::t_mac_ctl mac_ctl;
    pgki_pkg::t_mac_res mac_res;

    pgki_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (query_acc && (r_bw == 3'd1)),
        .i_os    (os_eff),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    pgki_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .o_res   (mac_res)
    );

    // Datapath helpers.
    always_comb begin
        in_acc    = i_in_valid && (r_state == pgki_pkg::S_IDLE);
        query_acc = in_acc && (i_action == pgki_pkg::ACT_QUERY);
        out_free  = !o_out_valid || !i_out_stall;
        os_eff    = (r_os_cfg == 10'd0) ? 10'd1 : r_os_cfg;
        tc_tab    = (32'(r_tap) > MAX_TAPS) ? TW'(MAX_TAPS) : TW'(r_tap);
        den       = {r_os, 16'h0000};
        carry     = r_rr >= 27'(den);
        rem       = r_rr - (carry ? 27'(den) : 27'd0);
        wx_n      = 18'(r_p[15:0]) + 18'(quot) - (carry ? 18'h10000 : 18'h00000);
        row_s     = $signed({2'b00, r_row}) - $signed(15'(r_half));
        col_s     = $signed({2'b00, r_col}) - $signed(14'(r_half));
        issue_addr = r_rowaddr + AW'(r_k);
        oor       = issue_addr[AW-1] || (issue_addr >= AW'(GRID_DEPTH));
        lastk     = r_k == KW'(r_tc - TW'(1));
        lastj     = r_j == KW'(r_tc - TW'(1));
        kl_isy    = r_kc >= (TW+1)'(r_tc);
        kl_pos    = kl_isy ? KW'(r_kc - (TW+1)'(r_tc)) : KW'(r_kc);
        kl_last   = r_kc == (TW+1)'({r_tc, 1'b0} - (TW+1)'(1));
        kidx      = kl_isy ? IW'(r_kyb) + IW'(kl_pos) : IW'(r_kxb) + IW'(kl_pos);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            pgki_pkg::S_IDLE:  if (query_acc) n_state = pgki_pkg::S_MUL1;
            pgki_pkg::S_MUL1:  n_state = pgki_pkg::S_MUL2;
            pgki_pkg::S_MUL2: begin
                if (r_tc == TW'(0)) n_state = pgki_pkg::S_FIN;
                else if (r_bil)     n_state = pgki_pkg::S_DIV;
                else                n_state = pgki_pkg::S_POS;
            end
            pgki_pkg::S_DIV:   if (!div_busy) n_state = pgki_pkg::S_POS;
            pgki_pkg::S_POS:   n_state = pgki_pkg::S_BASE;
            pgki_pkg::S_BASE:  n_state = r_bil ? pgki_pkg::S_RUN : pgki_pkg::S_KLOAD;
            pgki_pkg::S_KLOAD: if (kl_last) n_state = pgki_pkg::S_RUN;
            pgki_pkg::S_RUN:   if (lastk && lastj) n_state = pgki_pkg::S_DRAIN;
            pgki_pkg::S_DRAIN: if (mac_res.done) n_state = pgki_pkg::S_FIN;
            pgki_pkg::S_FIN:   if (out_free) n_state = pgki_pkg::S_IDLE;
            default:           n_state = pgki_pkg::S_IDLE;
        endcase
    end

    // State-dependent strobes.
    always_comb begin
        o_in_stall = 1'b1;
        grid_re    = 1'b0;
        kern_re    = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            pgki_pkg::S_IDLE:  o_in_stall = 1'b0;
            pgki_pkg::S_KLOAD: kern_re = 1'b1;
            pgki_pkg::S_RUN:   grid_re = 1'b1;
            pgki_pkg::S_FIN:   out_load = out_free;
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_comb begin
        mac_ctl.clr    = query_acc;
        mac_ctl.vld    = r_p1_vld;
        mac_ctl.last_k = r_p1_lastk;
        mac_ctl.last_j = r_p1_lastj;
        mac_ctl.bil    = (r_bw == 3'd1);
        mac_ctl.word   = r_p1_oor ? 32'sd0 : $signed(r_grid_q);
        mac_ctl.kx     = r_kx[r_p1_k];
        mac_ctl.ky     = r_ky[r_p1_j];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pgki_pkg::S_IDLE;
            r_ac     <= pgki_pkg::RST_ANGLE_COUNT;
            r_bw     <= pgki_pkg::RST_BORDER_WIDTH;
            r_tap    <= pgki_pkg::RST_TAP_COUNT;
            r_os_cfg <= pgki_pkg::RST_OVERSAMPLE;
            r_kl_vld <= 1'b0;
            r_p1_vld <= 1'b0;
            r_flag   <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pgki_pkg::CFG_ANGLE_COUNT:  r_ac     <= i_cfg_data;
                    pgki_pkg::CFG_BORDER_WIDTH: r_bw     <= i_cfg_data[2:0];
                    pgki_pkg::CFG_TAP_COUNT:    r_tap    <= i_cfg_data[3:0];
                    pgki_pkg::CFG_OVERSAMPLE:   r_os_cfg <= i_cfg_data[9:0];
                    default:                    r_ac     <= r_ac;
                endcase
            end
            r_kl_vld <= kern_re;
            r_p1_vld <= grid_re;
            if (query_acc) begin
                r_flag <= 1'b0;
            end else if (grid_re && oor) begin
                r_flag <= 1'b1;
            end
            if (out_load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Query set-up, counters and pipeline tags.
    always_ff @(posedge i_clk) begin
        if (query_acc) begin
            r_rad <= i_radius;
            r_ang <= i_angle[14:0];
            r_os  <= os_eff;
            r_bil <= (r_bw == 3'd1);
        end
        case (r_state)
            pgki_pkg::S_MUL1: begin
                r_p     <= {26'(r_ang * r_ac), 1'b0};
                r_ryp   <= 22'(r_os * r_rad[11:0]);
                r_row   <= 13'(r_rad[23:12]) + 13'(r_bw);
                r_width <= 12'(r_ac) + 12'({r_bw, 1'b0});
                r_tc    <= r_bil ? TW'(2) : tc_tab;
                r_half  <= r_bil ? TW'(0) : TW'((tc_tab - TW'(1)) >> 1);
            end
            pgki_pkg::S_MUL2: begin
                r_rr <= 27'(r_os * r_p[15:0]) + 27'd32768;
            end
            pgki_pkg::S_POS: begin
                r_col <= 12'(r_bw) + 12'(r_p[26:16]) + 12'(carry);
                r_rx  <= rem[25:16];
                r_wx  <= 17'(wx_n);
                r_ry  <= r_ryp[21:12];
            end
            pgki_pkg::S_BASE: begin
                r_rowaddr <= AW'(row_s * $signed({1'b0, r_width})) + AW'(col_s);
                r_kxb     <= 15'(r_rx * r_tc);
                r_kyb     <= 15'(r_ry * r_tc);
                r_kc      <= '0;
                r_k       <= '0;
                r_j       <= '0;
            end
            pgki_pkg::S_KLOAD: begin
                r_kc <= r_kc + (TW+1)'(1);
            end
            pgki_pkg::S_RUN: begin
                if (lastk) begin
                    r_k       <= '0;
                    r_j       <= r_j + KW'(1);
                    r_rowaddr <= r_rowaddr + AW'(r_width);
                end else begin
                    r_k <= r_k + KW'(1);
                end
            end
            default: begin
                r_kc <= r_kc;
            end
        endcase
        r_kl_oob   <= 32'(kidx) >= KERNEL_DEPTH;
        r_kl_isy   <= kl_isy;
        r_kl_pos   <= kl_pos;
        r_p1_oor   <= oor;
        r_p1_k     <= r_k;
        r_p1_j     <= r_j;
        r_p1_lastk <= lastk;
        r_p1_lastj <= lastj;
        if (out_load) begin
            o_sample       <= mac_res.sample;
            o_out_of_range <= r_flag;
        end
    end

    // Kernel coefficients: bilinear weights, or rows fetched from the table.
    always_ff @(posedge i_clk) begin
        if (r_state == pgki_pkg::S_BASE && r_bil) begin
            r_kx[0] <= $signed(18'h10000 - 18'(r_wx));
            r_kx[1] <= $signed(18'(r_wx));
            r_ky[0] <= $signed(18'h10000 - 18'({r_rad[11:0], 4'h0}));
            r_ky[1] <= $signed(18'({r_rad[11:0], 4'h0}));
        end else if (r_kl_vld) begin
            if (r_kl_isy) begin
                r_ky[r_kl_pos] <= r_kl_oob ? 18'sd0 : $signed(r_kern_q);
            end else begin
                r_kx[r_kl_pos] <= r_kl_oob ? 18'sd0 : $signed(r_kern_q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_action == pgki_pkg::ACT_GRID_WR) &&
            (32'(i_address) < GRID_DEPTH)) begin
            grid_mem[GAW'(i_address)] <= i_write_value;
        end
        if (grid_re) begin
            r_grid_q <= grid_mem[issue_addr[GAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_action == pgki_pkg::ACT_KERN_WR) &&
            (32'(i_address) < KERNEL_DEPTH)) begin
            kern_mem[KAW'(i_address)] <= i_write_value[17:0];
        end
        if (kern_re) begin
            r_kern_q <= kern_mem[kidx[KAW-1:0]];
        end
    end

    `ASSERT_IMP(a_done_in_drain, i_clk, i_rst_n, mac_res.done, r_state == pgki_pkg::S_DRAIN)
    `ASSERT_IMP(a_p1_after_run, i_clk, i_rst_n, r_p1_vld, $past(r_state) == pgki_pkg::S_RUN)
    `ASSERT_NXT(a_fin_waits, i_clk, i_rst_n, r_state == pgki_pkg::S_FIN && o_out_valid && i_out_stall, r_state == pgki_pkg::S_FIN)
    `ASSERT_IMP(a_bil_two_taps, i_clk, i_rst_n, r_state == pgki_pkg::S_RUN && r_bil, r_tc == TW'(2))

endmodule

### sv/pgki_recip.sv
// Bit-serial restoring divider giving floor(32768 / oversample).
// Depends on pgki_pkg for the dividend constant.
module pgki_recip (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [9:0]  i_os,
    output logic        o_busy,
    output logic [15:0] o_quot
);

    logic        r_busy;
    logic [3:0]  r_cnt;
    logic [9:0]  r_rem;
    logic [9:0]  r_os;
    logic [15:0] r_quot;
    logic [10:0] shifted;
    logic        ge;

    always_comb begin
        shifted = {r_rem, pgki_pkg::RECIP_NUM[r_cnt]};
        ge      = shifted >= {1'b0, r_os};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 4'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 4'd15;
            r_rem  <= 10'd0;
            r_os   <= i_os;
        end else if (r_busy) begin
            r_rem  <= ge ? 10'(shifted - {1'b0, r_os}) : shifted[9:0];
            r_quot <= {r_quot[14:0], ge};
            r_cnt  <= r_cnt - 4'd1;
            if (r_cnt == 4'd0) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

### sv/pgki_mac.sv
// Multiply-accumulate datapath: tap products, row sums, row weighting,
// final rounding and saturation. Depends on pgki_pkg for its structs.
module pgki_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pgki_pkg::t_mac_ctl  i_ctl,
    output pgki_pkg::t_mac_res  o_res
);

    logic               r_a_vld, r_a_lastk, r_a_lastj;
    logic signed [49:0] r_a_prod;
    logic signed [17:0] r_a_ky;
    logic signed [52:0] r_inner;
    logic               r_b_vld, r_b_lastj;
    logic signed [52:0] r_b_row;
    logic signed [17:0] r_b_ky;
    logic               r_c_vld, r_c_lastj;
    logic signed [63:0] r_c_term;
    logic signed [63:0] r_acc;
    logic               r_done;
    logic               r_bil;

    logic signed [31:0] word;
    logic signed [17:0] kx;
    logic signed [52:0] sum;
    logic signed [52:0] rnd;
    logic signed [64:0] fin;
    logic signed [48:0] shf;
    logic signed [31:0] sat;

    always_comb begin
        word = i_ctl.word;
        kx   = i_ctl.kx;
        sum  = r_inner + 53'(r_a_prod);
        rnd  = (sum + 53'sd32768) >>> 16;
        fin  = 65'(r_acc) + (r_bil ? 65'sd2147483648 : 65'sd32768);
        shf  = r_bil ? 49'(fin >>> 32) : 49'(fin >>> 16);
        if (shf > 49'sd2147483647) begin
            sat = 32'sh7FFFFFFF;
        end else if (shf < -49'sd2147483648) begin
            sat = 32'sh80000000;
        end else begin
            sat = 32'(shf);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_done  <= 1'b0;
            r_inner <= '0;
            r_acc   <= '0;
            r_bil   <= 1'b0;
        end else begin
            r_a_vld   <= i_ctl.vld;
            r_a_lastk <= i_ctl.last_k;
            r_a_lastj <= i_ctl.last_j;
            r_a_prod  <= 50'(word * kx);
            r_a_ky    <= i_ctl.ky;
            r_b_vld   <= 1'b0;
            r_c_vld   <= r_b_vld;
            r_c_lastj <= r_b_lastj;
            r_c_term  <= 64'(r_b_row * r_b_ky);
            r_done    <= r_c_vld && r_c_lastj;
            if (i_ctl.clr) begin
                r_inner <= '0;
                r_acc   <= '0;
                r_bil   <= i_ctl.bil;
            end else begin
                if (r_a_vld) begin
                    if (r_a_lastk) begin
                        // Bilinear rows stay at full precision; table rows round to Q16.
                        r_inner   <= '0;
                        r_b_vld   <= 1'b1;
                        r_b_row   <= r_bil ? sum : rnd;
                        r_b_ky    <= r_a_ky;
                        r_b_lastj <= r_a_lastj;
                    end else begin
                        r_inner <= sum;
                    end
                end
                if (r_c_vld) begin
                    r_acc <= r_acc + r_c_term;
                end
            end
        end
    end

    assign o_res.done   = r_done;
    assign o_res.sample = sat;

endmodule
